// ----- src/dsh_pkg.sv -----
// ----------------------------------------------------------------------------
// dsh_pkg: shared constants of the diamond-square heightfield generator
// Holds the widths of the square-root unit and the register and walk codes.
// ----------------------------------------------------------------------------
package dsh_pkg;

  // Radicand of the distance root: (dr^2+dc^2) scaled to Q.32 stays below 2^34.
  localparam int unsigned SQ_IN_W  = 34;
  // Root bits produced, one per iteration.
  localparam int unsigned SQ_OUT_W = 21;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRID_ORDER = 2'd0;
  localparam logic [1:0] CFG_MAX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_START_AMP  = 2'd2;

  // Walk phases within one level.
  localparam logic [1:0] PH_DIAMOND = 2'd0;
  localparam logic [1:0] PH_RIGHT   = 2'd1;
  localparam logic [1:0] PH_BOTTOM  = 2'd2;

endpackage

// ----- src/dsh_ram.sv -----
// ----------------------------------------------------------------------------
// dsh_ram: generic single-port RAM
// One access per cycle, read data registered and presented in the cycle after the address.
// ----------------------------------------------------------------------------
module dsh_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ----- src/dsh_isqrt.sv -----
// ----------------------------------------------------------------------------
// dsh_isqrt: iterative integer square root
// Produces the floor root one bit per cycle by the classic remainder method.
// ----------------------------------------------------------------------------
module dsh_isqrt
  import dsh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SQ_IN_W-1:0]  radicand_i,
  output logic                done_o,
  output logic [SQ_OUT_W-1:0] root_o
);

  localparam int unsigned RW = 2 * SQ_OUT_W;
  localparam int unsigned CNTW = $clog2(SQ_OUT_W + 1);

  logic [RW-1:0]   op_q, op_d;
  logic [RW-1:0]   res_q, res_d;
  logic [RW-1:0]   one_q, one_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [RW-1:0]   trial;

  assign trial = res_q + one_q;

  always_comb begin
    op_d   = op_q;
    res_d  = res_q;
    one_d  = one_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      op_d   = RW'(radicand_i);
      res_d  = '0;
      one_d  = RW'(1) << (RW - 2);
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (op_q >= trial) begin
        op_d  = op_q - trial;
        res_d = (res_q >> 1) + one_q;
      end else begin
        res_d = res_q >> 1;
      end
      one_d = one_q >> 2;
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(SQ_OUT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    res_q <= res_d;
    one_q <= one_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[SQ_OUT_W-1:0];

endmodule

// ----- src/diamond_square_heightfield_top.sv -----
// ----------------------------------------------------------------------------
// diamond_square_heightfield_top: wrapping diamond-square heightfield engine
// An item passes through four reads of the single-port height memory (S_RD0 to
// S_RD3), S_ACC, the 21-step root in S_SQRT, S_FIN and the write in S_WR1; a border
// point gives a second result in S_WR2. Each write waits while a result is stalled.
// The next item is taken in the cycle after the last write, and is stalled until then.
// Reset is asynchronous and active low: it loads the register defaults and
// restarts the walk; the height memory keeps no reset, corners read as zero.
// ----------------------------------------------------------------------------
module diamond_square_heightfield_top
  import dsh_pkg::*;
#(
  parameter int unsigned MAX_ORDER   = 9,
  parameter int unsigned HEIGHT_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            random_sample_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [MAX_ORDER:0]            row_o,
  output logic [MAX_ORDER:0]            col_o,
  output logic signed [HEIGHT_BITS-1:0] height_o,
  output logic                          last_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [18:0]                   cfg_data_i
);

  // Coordinates run from 0 to 2^MAX_ORDER, the store has a fixed row stride.
  localparam int unsigned CW     = MAX_ORDER + 1;
  localparam int unsigned STRIDE = (1 << MAX_ORDER) + 1;
  localparam int unsigned DEPTH  = STRIDE * STRIDE;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned OW     = $clog2(MAX_ORDER + 1);
  localparam int unsigned NF     = (MAX_ORDER + 1) * (MAX_ORDER + 1);
  localparam int unsigned FW     = $clog2(NF);
  localparam int unsigned HB     = HEIGHT_BITS;
  // Working width of mean plus random offset before the clamp.
  localparam int unsigned SW     = ((HB + 2 > 22) ? HB + 2 : 22) + 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_RD3  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_WR1  = 4'd8;
  localparam logic [3:0] S_WR2  = 4'd9;

  typedef struct packed {
    logic          hit;
    logic [OW-1:0] idx;
  } spec_t;

  // Clamps the order register into the supported range.
  function automatic logic [OW-1:0] eff_order(input logic [3:0] g);
    logic [OW-1:0] o;
    if (g == 4'd0) begin
      o = OW'(1);
    end else if (32'(g) > MAX_ORDER) begin
      o = OW'(MAX_ORDER);
    end else begin
      o = OW'(g);
    end
    return o;
  endfunction

  // Store address of a point, the stride multiply folded into shift and add.
  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return (AW'(r) << MAX_ORDER) + AW'(r) + AW'(c);
  endfunction

  // A coordinate that can be a corner of some grid: zero or 2^k with k >= 1.
  function automatic spec_t spec_of(input logic [CW-1:0] v);
    spec_t s;
    s.hit = (v == '0);
    s.idx = '0;
    for (int k = 1; k <= MAX_ORDER; k++) begin
      if (v == (CW'(1) << k)) begin
        s.hit = 1'b1;
        s.idx = OW'(k);
      end
    end
    return s;
  endfunction

  function automatic logic [FW-1:0] flag_idx(input spec_t a, input spec_t b);
    return FW'(32'(a.idx) * (MAX_ORDER + 1) + 32'(b.idx));
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never stalls; writes must be made only while
  // the engine is idle, which the block itself does not enforce; a write to the order
  // or the start amplitude simply restarts the walk below.
  // ---------------------------------------------------------------------------
  logic [3:0]  grid_order_q;
  logic [18:0] max_height_q;
  logic [18:0] start_amp_q;
  logic        cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // ---------------------------------------------------------------------------
  // Walk state. The square size is kept as its log2 (lvl), so the squares per
  // row and every coordinate product are shifts.
  // ---------------------------------------------------------------------------
  logic [OW-1:0]        lvl_q;
  logic [18:0]          amp_q;
  logic [MAX_ORDER-1:0] srow_q, scol_q;
  logic [1:0]           phase_q;

  logic [OW-1:0]        ord;
  logic [CW-1:0]        e_len;
  logic [CW-1:0]        half;
  logic [MAX_ORDER-1:0] nlast;
  logic [CW-1:0]        r0, c0, pr, pc;
  logic                 row_end, col_end, is_final;

  assign ord     = eff_order(grid_order_q);
  assign e_len   = CW'(1) << ord;
  assign half    = CW'(1) << (lvl_q - OW'(1));
  assign nlast   = MAX_ORDER'((CW'(1) << (ord - lvl_q)) - CW'(1));
  assign r0      = CW'(srow_q) << lvl_q;
  assign c0      = CW'(scol_q) << lvl_q;
  assign col_end = (scol_q == nlast);
  assign row_end = (srow_q == nlast);
  // The bottom point of the last square of the smallest level ends the field.
  assign is_final = (phase_q == PH_BOTTOM) && col_end && row_end && (lvl_q == OW'(1));

  always_comb begin
    pr = r0;
    pc = c0;
    case (phase_q)
      PH_DIAMOND: begin
        pr = r0 + half;
        pc = c0 + half;
      end
      PH_RIGHT:  pc = c0 + half;
      default:   pr = r0 + half;
    endcase
  end

  // Wrapping neighbour coordinates for edge points.
  logic [CW-1:0] up, dn, lf, rt;
  always_comb begin
    up = (pr >= half) ? pr - half : e_len - half;
    dn = (pr + half <= e_len) ? pr + half : half;
    lf = (pc >= half) ? pc - half : e_len - half;
    rt = (pc + half <= e_len) ? pc + half : half;
  end

  // ---------------------------------------------------------------------------
  // Per-item registers.
  // ---------------------------------------------------------------------------
  logic [3:0]                state_q, state_d;
  logic [CW-1:0]             rdr_q [4];
  logic [CW-1:0]             rdc_q [4];
  logic [CW-1:0]             pr_q, pc_q, cr_q, cc_q;
  logic                      copy_q, final_q;
  logic signed [35:0]        prod1_q;
  logic signed [57:0]        prod2_q;
  logic signed [HB+1:0]      sum_q;
  logic signed [HB-1:0]      h_q;
  logic                      acc_en_q, rzero_q;
  logic [NF-1:0]             cflag_q;
  logic                      in_fire, out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Distance from the grid centre, Q.16, from an iterative root.
  // ---------------------------------------------------------------------------
  logic signed [CW+1:0]  dr, dc;
  logic [2*CW-1:0]       sumsq;
  logic [SQ_IN_W-1:0]    radicand;
  logic                  sq_start, sq_done;
  logic [SQ_OUT_W-1:0]   sq_root;

  assign dr       = $signed({1'b0, pr_q, 1'b0}) - $signed((CW + 2)'(e_len));
  assign dc       = $signed({1'b0, pc_q, 1'b0}) - $signed((CW + 2)'(e_len));
  assign sumsq    = (2 * CW)'(dr * dr) + (2 * CW)'(dc * dc);
  assign radicand = SQ_IN_W'(sumsq) << (6'd32 - {1'b0, 6'(ord), 1'b0}) ;
  assign sq_start = (state_q == S_RD0);

  dsh_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // ---------------------------------------------------------------------------
  // Height memory: reads of the four neighbours, then one or two writes.
  // ---------------------------------------------------------------------------
  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [HB-1:0] mem_rdata;
  logic [1:0]    rsel;
  logic          rd_state;
  logic [CW-1:0] rd_r, rd_c, wr_r, wr_c;
  spec_t         rs_r, rs_c, ws_r, ws_c;

  assign rd_state = (state_q == S_RD0) || (state_q == S_RD1) ||
                    (state_q == S_RD2) || (state_q == S_RD3);
  assign rsel     = 2'(state_q - S_RD0);
  assign rd_r     = rdr_q[rsel];
  assign rd_c     = rdc_q[rsel];
  assign wr_r     = (state_q == S_WR2) ? cr_q : pr_q;
  assign wr_c     = (state_q == S_WR2) ? cc_q : pc_q;
  assign mem_we   = ((state_q == S_WR1) || (state_q == S_WR2)) && out_free;
  assign mem_en   = rd_state || mem_we;
  assign mem_addr = mem_we ? addr_of(wr_r, wr_c) : addr_of(rd_r, rd_c);
  assign rs_r     = spec_of(rd_r);
  assign rs_c     = spec_of(rd_c);
  assign ws_r     = spec_of(wr_r);
  assign ws_c     = spec_of(wr_c);

  dsh_ram #(
    .WIDTH (HB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (h_q),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Height: floored mean plus random offset, clamped.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] mean, rnd, v, lim, cap, hv;

  assign mean = SW'(sum_q >>> 2);
  assign rnd  = SW'(prod2_q >>> 31);
  assign v    = mean + rnd;
  assign cap  = SW'((64'd1 << (HB - 1)) - 64'd1);
  assign lim  = ($signed(SW'(max_height_q)) > cap) ? cap : $signed(SW'(max_height_q));
  always_comb begin
    hv = v;
    if (v > lim) begin
      hv = lim;
    end else if (v < -lim) begin
      hv = -lim;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_RD0;
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_RD3;
      S_RD3:  state_d = S_ACC;
      S_ACC:  state_d = S_SQRT;
      S_SQRT: if (sq_done) state_d = S_FIN;
      S_FIN:  state_d = S_WR1;
      S_WR1:  if (out_free) state_d = copy_q ? S_WR2 : S_IDLE;
      S_WR2:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      grid_order_q <= 4'd9;
      max_height_q <= 19'd25600;
      start_amp_q  <= 19'd12800;
      lvl_q        <= eff_order(4'd9);
      amp_q        <= 19'd12800;
      srow_q       <= '0;
      scol_q       <= '0;
      phase_q      <= PH_DIAMOND;
      out_valid_o  <= 1'b0;
      acc_en_q     <= 1'b0;
      cflag_q      <= '0;
    end else begin
      state_q  <= state_d;
      acc_en_q <= rd_state;

      if (cfg_fire) begin
        unique case (cfg_index_i)
          CFG_GRID_ORDER: begin
            grid_order_q <= cfg_data_i[3:0];
            lvl_q        <= eff_order(cfg_data_i[3:0]);
            amp_q        <= start_amp_q;
            srow_q       <= '0;
            scol_q       <= '0;
            phase_q      <= PH_DIAMOND;
          end
          CFG_MAX_HEIGHT: max_height_q <= cfg_data_i;
          CFG_START_AMP: begin
            start_amp_q <= cfg_data_i;
            lvl_q       <= ord;
            amp_q       <= cfg_data_i;
            srow_q      <= '0;
            scol_q      <= '0;
            phase_q     <= PH_DIAMOND;
          end
          default: ;
        endcase
      end

      // The walk moves on as soon as the point's coordinates are latched.
      if (in_fire) begin
        if (phase_q == PH_RIGHT) begin
          phase_q <= PH_BOTTOM;
        end else if (!col_end) begin
          scol_q <= scol_q + MAX_ORDER'(1);
          if (phase_q == PH_BOTTOM) phase_q <= PH_RIGHT;
        end else begin
          scol_q <= '0;
          if (!row_end) begin
            srow_q <= srow_q + MAX_ORDER'(1);
            if (phase_q == PH_BOTTOM) phase_q <= PH_RIGHT;
          end else begin
            srow_q <= '0;
            if (phase_q == PH_DIAMOND) begin
              phase_q <= PH_RIGHT;
            end else begin
              phase_q <= PH_DIAMOND;
              if (lvl_q == OW'(1)) begin
                // Field complete: start again at the largest level.
                lvl_q <= ord;
                amp_q <= start_amp_q;
              end else begin
                lvl_q <= lvl_q - OW'(1);
                amp_q <= amp_q >> 1;
              end
            end
          end
        end
      end

      if (mem_we && ws_r.hit && ws_c.hit) begin
        cflag_q[flag_idx(ws_r, ws_c)] <= 1'b1;
      end

      if (mem_we) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pr_q    <= pr;
      pc_q    <= pc;
      final_q <= is_final;
      prod1_q <= random_sample_i * $signed({1'b0, amp_q});
      sum_q   <= '0;
      if (phase_q == PH_DIAMOND) begin
        rdr_q[0] <= r0;           rdc_q[0] <= c0;
        rdr_q[1] <= r0 + (half << 1); rdc_q[1] <= c0;
        rdr_q[2] <= r0;           rdc_q[2] <= c0 + (half << 1);
        rdr_q[3] <= r0 + (half << 1); rdc_q[3] <= c0 + (half << 1);
        copy_q   <= 1'b0;
      end else begin
        rdr_q[0] <= up; rdc_q[0] <= pc;
        rdr_q[1] <= dn; rdc_q[1] <= pc;
        rdr_q[2] <= pr; rdc_q[2] <= lf;
        rdr_q[3] <= pr; rdc_q[3] <= rt;
        copy_q   <= (pr == '0) || (pc == '0);
      end
      // Top border copies to the bottom row, left border to the right column.
      cr_q <= (pr == '0) ? e_len : pr;
      cc_q <= (pr == '0) ? pc : e_len;
    end

    // A never-written corner reads as zero.
    if (rd_state) begin
      rzero_q <= rs_r.hit && rs_c.hit && !cflag_q[flag_idx(rs_r, rs_c)];
    end
    if (acc_en_q) begin
      sum_q <= sum_q + (rzero_q ? (HB + 2)'(0) : {{2{mem_rdata[HB-1]}}, mem_rdata});
    end

    if ((state_q == S_SQRT) && sq_done) begin
      prod2_q <= prod1_q * $signed({1'b0, sq_root});
    end
    if (state_q == S_FIN) begin
      h_q <= HB'(hv);
    end

    if (mem_we) begin
      row_o    <= wr_r;
      col_o    <= wr_c;
      height_o <= h_q;
      last_o   <= final_q && ((state_q == S_WR2) || !copy_q);
    end
  end

endmodule

// ----- test/diamond_square_heightfield_top_tb.sv -----
// ----------------------------------------------------------------------------
// diamond_square_heightfield_top_tb: self-checking bench for the heightfield
// A behavioural predictor of the wrapping diamond-square walk is kept in step
// with every accepted sample. Each emitted point is checked against it. Both
// channels idle at random, and the registers are changed between phases.
// ----------------------------------------------------------------------------
module diamond_square_heightfield_top_tb
  import dsh_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ORD    = 9;
  localparam int unsigned HBITS      = 20;
  localparam int unsigned STRIDE     = (1 << MAX_ORD) + 1;
  localparam int unsigned DEPTH      = STRIDE * STRIDE;
  localparam int unsigned CYCLE_CAP  = 2000000;
  // Settling wait after the last expected point; this covers the tail.
  localparam int unsigned DRAIN_WAIT = 40;

  typedef struct packed {
    logic [MAX_ORD:0]        row;
    logic [MAX_ORD:0]        col;
    logic signed [HBITS-1:0] height;
    logic                    last;
  } point_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [15:0]      random_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [MAX_ORD:0]        row_o;
  logic [MAX_ORD:0]        col_o;
  logic signed [HBITS-1:0] height_o;
  logic                    last_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [1:0]              cfg_index_i = '0;
  logic [18:0]             cfg_data_i = '0;

  diamond_square_heightfield_top #(
    .MAX_ORDER  (MAX_ORD),
    .HEIGHT_BITS(HBITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .random_sample_i(random_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_o          (row_o),
    .col_o          (col_o),
    .height_o       (height_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: its own copy of the registers, the walk and the store.
  logic signed [HBITS-1:0] height_mem [DEPTH];
  logic [3:0]  reg_order;
  logic [18:0] reg_max_height;
  logic [18:0] reg_start_amp;
  int unsigned walk_len;
  logic [19:0] walk_amp;
  int unsigned sq_row, sq_col;
  logic [1:0]  walk_phase;

  point_t      pending_points[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  // When set, neither side idles, giving back-to-back stretches.
  bit          no_idle = 1'b0;

  function automatic int unsigned order_used();
    if (reg_order < 1) return 1;
    if (reg_order > MAX_ORD) return MAX_ORD;
    return reg_order;
  endfunction

  function automatic void restart_walk();
    walk_len   = (1 << order_used()) + 1;
    walk_amp   = {1'b0, reg_start_amp};
    sq_row     = 0;
    sq_col     = 0;
    walk_phase = PH_DIAMOND;
  endfunction

  function automatic longint read_height(int unsigned r, int unsigned c);
    return longint'(height_mem[r * STRIDE + c]);
  endfunction

  // Bit-serial root over 21 result bits, giving the same floor root as the distance unit.
  function automatic longint unsigned root21(longint unsigned x);
    longint unsigned res, cand;
    res = 0;
    for (int i = 20; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if (cand * cand <= x) res = cand;
    end
    return res;
  endfunction

  function automatic logic signed [HBITS-1:0] point_height(longint sum4, int unsigned r,
                                                         int unsigned c, longint sample);
    int unsigned     ord;
    longint          e, dr, dc, d, rnd, v, lim;
    longint unsigned radicand;
    ord = order_used();
    e  = longint'(1) << ord;
    dr = 2 * longint'(r) - e;
    dc = 2 * longint'(c) - e;
    radicand = longint'(dr * dr + dc * dc) << (32 - 2 * ord);
    d   = longint'(root21(radicand));
    rnd = (sample * longint'(walk_amp) * d) >>> 31;
    v   = (sum4 >>> 2) + rnd;
    lim = longint'(reg_max_height);
    if (lim > (longint'(1) << (HBITS - 1)) - 1) lim = (longint'(1) << (HBITS - 1)) - 1;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[HBITS-1:0];
  endfunction

  function automatic void expect_point(int unsigned r, int unsigned c,
                                       logic signed [HBITS-1:0] h);
    point_t p;
    height_mem[r * STRIDE + c] = h;
    p.row = r[MAX_ORD:0];
    p.col = c[MAX_ORD:0];
    p.height = h;
    p.last = 1'b0;
    pending_points.push_back(p);
  endfunction

  // Works out the points that one accepted sample writes, and steps the walk.
  function automatic void predict_points(logic signed [15:0] sample);
    int unsigned edge_pts, e, span, half, n, r, c, r0, c0, up, dn, lf, rt;
    longint      sum;
    logic signed [HBITS-1:0] h;
    point_t      tail;
    edge_pts = (1 << order_used()) + 1;
    e = edge_pts - 1;
    if (walk_len < 3 || walk_len > edge_pts) restart_walk();
    span = walk_len - 1;
    half = span / 2;
    n    = e / span;
    if (walk_phase == PH_DIAMOND) begin
      r0 = sq_row * span;
      c0 = sq_col * span;
      r = r0 + half;
      c = c0 + half;
      sum = read_height(r0, c0) + read_height(r0 + span, c0) +
            read_height(r0, c0 + span) + read_height(r0 + span, c0 + span);
      h = point_height(sum, r, c, longint'(sample));
      expect_point(r, c, h);
    end else begin
      r = sq_row * span;
      c = sq_col * span;
      if (walk_phase == PH_RIGHT) c += half;
      else r += half;
      up = (r >= half) ? r - half : e - half;
      dn = (r + half < edge_pts) ? r + half : half;
      lf = (c >= half) ? c - half : e - half;
      rt = (c + half < edge_pts) ? c + half : half;
      sum = read_height(up, c) + read_height(dn, c) + read_height(r, lf) +
            read_height(r, rt);
      h = point_height(sum, r, c, longint'(sample));
      expect_point(r, c, h);
      // A point on the top or left border is mirrored to the far border.
      if (r == 0) expect_point(e, c, h);
      else if (c == 0) expect_point(r, e, h);
    end
    if (walk_phase == PH_RIGHT) begin
      walk_phase = PH_BOTTOM;
    end else begin
      sq_col++;
      if (sq_col >= n) begin
        sq_col = 0;
        sq_row++;
        if (sq_row >= n) begin
          sq_row = 0;
          if (walk_phase == PH_DIAMOND) begin
            walk_phase = PH_RIGHT;
          end else begin
            walk_phase = PH_DIAMOND;
            walk_len = walk_len / 2 + 1;
            walk_amp = walk_amp >> 1;
            if (walk_len <= 2) begin
              // The final point of the field carries the last flag.
              tail = pending_points.pop_back();
              tail.last = 1'b1;
              pending_points.push_back(tail);
              restart_walk();
            end
          end
        end
      end
      if (walk_phase == PH_BOTTOM) walk_phase = PH_RIGHT;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // The receiving side stalls in runs of random length.
  initial begin
    int unsigned run;
    forever begin
      @(negedge clk_i);
      run = idle_gap();
      if (run != 0) begin
        out_stall_i <= 1'b1;
        repeat (run - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Every result transfer is checked against the oldest pending point.
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point row %0d col %0d height %0d last %0b",
                   row_o, col_o, height_o, last_o);
      end else begin
        want = pending_points.pop_front();
        if (want.row !== row_o || want.col !== col_o || want.height !== height_o ||
            want.last !== last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: expected row %0d col %0d height %0d last %0b, %s",
                     want.row, want.col, want.height, want.last,
                     $sformatf("got row %0d col %0d height %0d last %0b",
                               row_o, col_o, height_o, last_o));
        end
      end
    end
  end

  // A generous cycle cap stops a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sends one sample; the prediction is made at the transfer edge. The valid
  // is raised on a later falling edge than the one that dropped it.
  task automatic send_sample(logic signed [15:0] sample);
    int unsigned gap;
    gap = idle_gap();
    repeat (gap + 1) @(negedge clk_i);
    in_valid_i      <= 1'b1;
    random_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    predict_points(sample);
    sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits until every predicted point has been seen, then lets the tail settle.
  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register writes are only made once the block has gone quiet.
  task automatic write_reg(logic [1:0] index, logic [18:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_GRID_ORDER: begin
        reg_order = data[3:0];
        restart_walk();
      end
      CFG_MAX_HEIGHT: begin
        reg_max_height = data;
      end
      CFG_START_AMP: begin
        reg_start_amp = data;
        restart_walk();
      end
      default: begin
        // Indexes past the register list are ignored.
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_field(logic [3:0] ord, logic [18:0] lim, logic [18:0] amp);
    write_reg(CFG_GRID_ORDER, {15'd0, ord});
    write_reg(CFG_MAX_HEIGHT, lim);
    write_reg(CFG_START_AMP, amp);
  endtask

  // Defaults after reset, with the largest grid and the extreme samples.
  task automatic test_reset_defaults();
    logic signed [15:0] corner_samples[6];
    corner_samples = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh7fff};
    no_idle = 1'b1;
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    no_idle = 1'b0;
    repeat (4) send_sample(16'($urandom));
  endtask

  // Register extremes: out-of-range orders, zero and full clamp limits.
  task automatic test_register_extremes();
    logic signed [15:0] full_field[5];
    full_field = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh4000};
    // Order zero acts as order one, a field of five points.
    set_field(4'd0, 19'h7ffff, 19'h7ffff);
    foreach (full_field[i]) send_sample(full_field[i]);
    // A zero clamp limit forces every height to zero.
    write_reg(CFG_MAX_HEIGHT, 19'd0);
    foreach (full_field[i]) send_sample(full_field[i]);
    // An index past the register list must leave the walk alone.
    write_reg(2'd3, 19'($urandom));
    write_reg(CFG_MAX_HEIGHT, 19'd1);
    send_sample(16'sh7fff);
    // Order fifteen acts as the largest order.
    set_field(4'd15, 19'd25600, 19'd0);
    repeat (3) send_sample(16'($urandom));
  endtask

  // Random fields, mostly whole and small, with a few partial larger ones.
  task automatic test_random_fields();
    logic [3:0]  ord;
    logic [18:0] lim, amp;
    int unsigned points, pick;
    while (sent < 620) begin
      pick = $urandom_range(0, 9);
      ord  = (pick < 3) ? 4'd1 : (pick < 6) ? 4'd2 : (pick < 8) ? 4'd3 : (pick < 9) ? 4'd4 : 4'd5;
      pick = $urandom_range(0, 5);
      lim  = (pick == 0) ? 19'h7ffff : (pick == 1) ? 19'($urandom_range(1, 255)) : 19'($urandom);
      pick = $urandom_range(0, 5);
      amp  = (pick == 0) ? 19'h7ffff : (pick == 1) ? 19'd0 : 19'($urandom);
      set_field(ord, lim, amp);
      points = ((1 << ord) + 1) * ((1 << ord) + 1) - 4;
      if (ord >= 4) points = $urandom_range(30, 120);
      else if ($urandom_range(0, 3) == 0) points = points * 2;
      no_idle = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < points; i++) begin
        send_sample(16'($urandom));
        // Hold off now and then until the block has caught up.
        if (i == points / 2 && $urandom_range(0, 2) == 0) wait_drained();
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    reg_order      = 4'd9;
    reg_max_height = 19'd25600;
    reg_start_amp  = 19'd12800;
    foreach (height_mem[i]) height_mem[i] = '0;
    restart_walk();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    wait_drained();
    test_register_extremes();
    test_random_fields();
    wait_drained();

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dsh_pkg.sv
src/dsh_ram.sv
src/dsh_isqrt.sv
src/diamond_square_heightfield_top.sv
test/diamond_square_heightfield_top_tb.sv
